FILE: rtl/clcd_pkg.sv
`default_nettype none
package clcd_pkg;

    localparam int unsigned AP_W     = 10;
    localparam int unsigned CMD_S_W  = 13;
    localparam int unsigned CHR_S_W  = 10;
    localparam int unsigned EN_W     = 8;
    localparam int unsigned WAIT_W   = 15;
    localparam int unsigned EXTRA_W  = 15;
    localparam int unsigned CLR_W    = 11;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 13;

    localparam logic [WAIT_W-1:0]  WAIT_MAX       = 15'h7FFF;
    localparam logic [EXTRA_W-1:0] POWER_WAIT_US  = 15'd20000;
    localparam logic [EXTRA_W-1:0] FIRST_EXTRA_US = 15'd5000;
    localparam logic [EXTRA_W-1:0] SECOND_EXTRA_US = 15'd150;
    localparam logic [CLR_W-1:0]   CLEAR_EXTRA_US = 11'd2000;

    localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
    localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
    localparam logic [7:0] BYTE_ENTRY    = 8'h06;
    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
    localparam logic [3:0] NIB_NONE      = 4'h0;

    localparam logic [STEP_W-1:0] STEP_POWER   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WAKE0   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE1   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WAKE2   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_4BIT    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_BYTE_HI = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FINAL   = 4'd12;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CMD    = 3'd1,
        OP_CHAR   = 3'd2,
        OP_CURSOR = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_ENABLE_HIGH  = 3'd0,
        REG_AFTER_PULSE  = 3'd1,
        REG_CMD_SETTLE   = 3'd2,
        REG_CHAR_SETTLE  = 3'd3
    } t_reg_ix;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SEND
    } t_state;

    typedef struct packed {
        logic [AP_W-1:0]    base;
        logic [EXTRA_W-1:0] extra;
        logic [CLR_W-1:0]   clear;
    } t_wait_terms;

    function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        case (step)
            4'd5, 4'd6:  b = BYTE_FUNC_SET;
            4'd7, 4'd8:  b = BYTE_DISP_ON;
            4'd9, 4'd10: b = BYTE_ENTRY;
            default:     b = BYTE_CLEAR;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/clcd_wait_sat.sv
`default_nettype none
module clcd_wait_sat (
    input  clcd_pkg::t_wait_terms                i_terms,
    output logic [clcd_pkg::WAIT_W-1:0]          o_wait_us
);
    import clcd_pkg::*;

    logic [WAIT_W+1:0] sum;

    assign sum = (WAIT_W+2)'(i_terms.base) + (WAIT_W+2)'(i_terms.extra)
               + (WAIT_W+2)'(i_terms.clear);

    assign o_wait_us = (sum > (WAIT_W+2)'(WAIT_MAX)) ? WAIT_MAX : sum[WAIT_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/char_lcd_4bit_interface_sequencer.sv
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_ready      i_cmd i_value i_column i_line
// out       source     o_out_valid / i_out_ready    o_register_select o_nibble o_pulse
//                                                   o_wait_us o_last
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index i_cfg_data
//
// Each transfer forms its word in S_LOAD through the shared wait adder and presents it
// in S_SEND. A byte operation sends two words, init thirteen, plus output stalls.
// An unknown operation is accepted and gives nothing.
// Synchronous active-low reset returns to idle with the register reset values.
// o_in_ready is high only in idle; a stalled output word holds until taken.
`default_nettype none
module char_lcd_4bit_interface_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [2:0]                       i_cmd,
    input  wire logic [7:0]                       i_value,
    input  wire logic [5:0]                       i_column,
    input  wire logic                             i_line,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_register_select,
    output logic [3:0]                            o_nibble,
    output logic                                  o_pulse,
    output logic [clcd_pkg::WAIT_W-1:0]           o_wait_us,
    output logic                                  o_last,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [clcd_pkg::CFG_IX_W-1:0]    i_cfg_index,
    input  wire logic [clcd_pkg::CFG_D_W-1:0]     i_cfg_data
);
    import clcd_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_init, r_clear, r_rs;
    logic [7:0]          r_byte;

    logic [EN_W-1:0]     r_enable_high_us;
    logic [AP_W-1:0]     r_after_pulse_us;
    logic [CMD_S_W-1:0]  r_cmd_settle_us;
    logic [CHR_S_W-1:0]  r_char_settle_us;

    logic                r_o_rs, r_o_pulse, r_o_last;
    logic [3:0]          r_o_nib;
    logic [WAIT_W-1:0]   r_o_wait;

    logic                in_acc, known_op, clear_now, lo_nib, d_pulse;
    logic [7:0]          cur_byte;
    logic [3:0]          d_nib;
    t_wait_terms         terms;
    logic [WAIT_W-1:0]   sum_wait;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign known_op    = (i_cmd <= 3'(OP_CLEAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high_us <= 8'd1;
            r_after_pulse_us <= 10'd100;
            r_cmd_settle_us  <= 13'd2000;
            r_char_settle_us <= 10'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_ix'(i_cfg_index))
                REG_ENABLE_HIGH: r_enable_high_us <= i_cfg_data[EN_W-1:0];
                REG_AFTER_PULSE: r_after_pulse_us <= i_cfg_data[AP_W-1:0];
                REG_CMD_SETTLE:  r_cmd_settle_us  <= i_cfg_data[CMD_S_W-1:0];
                REG_CHAR_SETTLE: r_char_settle_us <= i_cfg_data[CHR_S_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_POWER;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_init  <= (i_cmd == OP_INIT);
            r_clear <= (i_cmd == OP_CLEAR);
            r_rs    <= (i_cmd == OP_CHAR);
            case (t_op'(i_cmd))
                OP_CURSOR: r_byte <= {1'b1, i_line, i_column};
                OP_CLEAR:  r_byte <= BYTE_CLEAR;
                default:   r_byte <= i_value;
            endcase
        end
        if (r_state == S_LOAD) begin
            r_o_rs    <= r_rs;
            r_o_nib   <= d_nib;
            r_o_pulse <= d_pulse;
            r_o_wait  <= sum_wait;
            r_o_last  <= (r_step == STEP_FINAL);
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (in_acc && known_op) begin
                    n_state = S_LOAD;
                    n_step  = (i_cmd == OP_INIT) ? STEP_POWER : STEP_BYTE_HI;
                end
            end
            S_LOAD: n_state = S_SEND;
            S_SEND: begin
                if (i_out_ready) begin
                    if (r_step == STEP_FINAL) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_LOAD;
                        n_step  = r_step + STEP_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign cur_byte  = r_init ? init_byte(r_step) : r_byte;
    assign lo_nib    = !r_step[0];
    assign clear_now = r_clear || (r_init && r_step >= STEP_BYTE_HI);

    always_comb begin
        d_pulse     = 1'b1;
        d_nib       = lo_nib ? cur_byte[3:0] : cur_byte[7:4];
        terms.base  = r_after_pulse_us;
        terms.extra = '0;
        terms.clear = '0;
        if (r_init && r_step <= STEP_4BIT) begin
            d_nib = NIB_WAKE;
            case (r_step)
                STEP_POWER: begin
                    d_pulse     = 1'b0;
                    d_nib       = NIB_NONE;
                    terms.base  = '0;
                    terms.extra = POWER_WAIT_US;
                end
                STEP_WAKE0: terms.extra = FIRST_EXTRA_US;
                STEP_WAKE1: terms.extra = SECOND_EXTRA_US;
                STEP_WAKE2: terms.extra = '0;
                STEP_4BIT:  d_nib = NIB_FOUR_BIT;
                default: ;
            endcase
        end else if (lo_nib) begin
            terms.extra = r_rs ? EXTRA_W'(r_char_settle_us) : EXTRA_W'(r_cmd_settle_us);
            terms.clear = clear_now ? CLEAR_EXTRA_US : '0;
        end
    end

    clcd_wait_sat u_wait (
        .i_terms   (terms),
        .o_wait_us (sum_wait)
    );

    assign o_out_valid       = (r_state == S_SEND);
    assign o_register_select = r_o_rs;
    assign o_nibble          = r_o_nib;
    assign o_pulse           = r_o_pulse;
    assign o_wait_us         = r_o_wait;
    assign o_last            = r_o_last;

    logic unused_en;
    assign unused_en = ^r_enable_high_us;

endmodule
`default_nettype wire

FILE: rtl/clcd_checker.sv
`default_nettype none
module clcd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [2:0]                    i_cmd,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_register_select,
    input wire logic [3:0]                    o_nibble,
    input wire logic                          o_pulse,
    input wire logic [clcd_pkg::WAIT_W-1:0]   o_wait_us
);
    import clcd_pkg::*;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a word is pending");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_wait_us)
            && $stable(o_nibble))
        else $error("stalled output word changed");

    a_plain_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pulse |-> o_nibble == NIB_NONE && o_wait_us == POWER_WAIT_US
            && !o_register_select)
        else $error("plain wait has wrong fields");

    a_op_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd <= 3'(OP_CLEAR) |=> !o_in_ready)
        else $error("ready stayed high after an operation was taken");

    a_data_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_register_select |-> o_pulse)
        else $error("data word without enable pulse");

endmodule

bind char_lcd_4bit_interface_sequencer clcd_checker u_clcd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_cmd             (i_cmd),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_register_select (o_register_select),
    .o_nibble          (o_nibble),
    .o_pulse           (o_pulse),
    .o_wait_us         (o_wait_us)
);
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clcd_pkg::*;

    localparam int unsigned LCD_WAIT_CAP    = 32767;
    localparam int unsigned POWER_UP_US     = 20000;
    localparam int unsigned WAKE_FIRST_US   = 5000;
    localparam int unsigned WAKE_SECOND_US  = 150;
    localparam int unsigned CLEAR_HOLD_US   = 2000;
    localparam logic [7:0]  FUNC_SET_CODE   = 8'h28;
    localparam logic [7:0]  DISPLAY_ON_CODE = 8'h0C;
    localparam logic [7:0]  ENTRY_MODE_CODE = 8'h06;
    localparam logic [7:0]  CLEAR_CODE      = 8'h01;
    localparam logic [7:0]  SET_DDRAM       = 8'h80;
    localparam logic [7:0]  ROW1_BASE       = 8'h40;
    localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0]  BUS4_NIBBLE     = 4'h2;

    localparam logic [2:0] OP_BAD_LO  = 3'd5;
    localparam logic [2:0] OP_BAD_MID = 3'd6;
    localparam logic [2:0] OP_BAD_HI  = 3'd7;
    localparam logic [CFG_IX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic              rs;
        logic [3:0]        nib;
        logic              pulse;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_bus_xfer;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_BYTE
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [2:0]        cmd;
        logic [7:0]        value;
        logic [5:0]        column;
        logic              line;
        logic              rs;
        logic [7:0]        code;
        logic [WAIT_W-1:0] hi_wait;
        logic [WAIT_W-1:0] lo_wait;
    } t_row;

    localparam int DIRECTED_ROWS = 18;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_PREDICT, OP_INIT,   8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_BYTE,    OP_CMD,    8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CMD,    8'hFF, 6'd63, 1'b1, 1'b0, 8'hFF, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CHAR,   8'h00, 6'd0,  1'b0, 1'b1, 8'h00, 15'd100, 15'd150},
        '{ROW_BYTE,    OP_CHAR,   8'hFF, 6'd0,  1'b0, 1'b1, 8'hFF, 15'd100, 15'd150},
        '{ROW_PREDICT, OP_CHAR,   8'hA5, 6'd0,  1'b0, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_BYTE,    OP_CURSOR, 8'h00, 6'd0,  1'b0, 1'b0, 8'h80, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0, 8'hFF, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CURSOR, 8'hFF, 6'd63, 1'b0, 1'b0, 8'hBF, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CURSOR, 8'h00, 6'd0,  1'b1, 1'b0, 8'hC0, 15'd100, 15'd2100},
        '{ROW_BYTE,    OP_CLEAR,  8'h00, 6'd0,  1'b0, 1'b0, 8'h01, 15'd100, 15'd4100},
        '{ROW_NONE,    OP_BAD_LO, 8'hFF, 6'd63, 1'b1, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_NONE,    OP_BAD_MID, 8'h5A, 6'd21, 1'b0, 1'b0, 8'h00, 15'd0,  15'd0},
        '{ROW_NONE,    OP_BAD_HI, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_PREDICT, OP_CMD,    8'h5A, 6'd0,  1'b0, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_PREDICT, OP_CURSOR, 8'h00, 6'd21, 1'b1, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_PREDICT, OP_CLEAR,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 15'd0,   15'd0},
        '{ROW_PREDICT, OP_INIT,   8'hC3, 6'd42, 1'b1, 1'b0, 8'h00, 15'd0,   15'd0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_cmd;
    logic [7:0]          i_value;
    logic [5:0]          i_column;
    logic                i_line;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_register_select;
    logic [3:0]          o_nibble;
    logic                o_pulse;
    logic [WAIT_W-1:0]   o_wait_us;
    logic                o_last;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [CFG_D_W-1:0]  i_cfg_data;

    t_bus_xfer   lcd_xfers_due[$];
    t_row        cur_row;
    int          mismatches;
    bit          feed_gappy;
    bit          drain_gappy;

    logic [7:0]  en_high_us;
    logic [9:0]  pulse_gap_us;
    logic [12:0] cmd_settle_us;
    logic [9:0]  chr_settle_us;

    char_lcd_4bit_interface_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_value           (i_value),
        .i_column          (i_column),
        .i_line            (i_line),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_register_select (o_register_select),
        .o_nibble          (o_nibble),
        .o_pulse           (o_pulse),
        .o_wait_us         (o_wait_us),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void add_xfer(logic rs, logic [3:0] nib, logic pulse, int unsigned us);
        t_bus_xfer x;
        x.rs      = rs;
        x.nib     = nib;
        x.pulse   = pulse;
        x.wait_us = WAIT_W'((us > LCD_WAIT_CAP) ? LCD_WAIT_CAP : us);
        x.last    = 1'b0;
        lcd_xfers_due.push_back(x);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] code, int unsigned extra_us);
        add_xfer(rs, code[7:4], 1'b1, pulse_gap_us);
        add_xfer(rs, code[3:0], 1'b1, pulse_gap_us + extra_us);
    endfunction

    function automatic void predict_bus_xfers(logic [2:0] op, logic [7:0] val,
                                              logic [5:0] col, logic ln);
        int unsigned held;
        logic [7:0]  ddram;
        held  = lcd_xfers_due.size();
        ddram = (ln ? ROW1_BASE : 8'h00) + {2'b00, col};
        case (op)
            OP_INIT: begin
                add_xfer(1'b0, 4'h0, 1'b0, POWER_UP_US);
                add_xfer(1'b0, WAKE_NIBBLE, 1'b1, pulse_gap_us + WAKE_FIRST_US);
                add_xfer(1'b0, WAKE_NIBBLE, 1'b1, pulse_gap_us + WAKE_SECOND_US);
                add_xfer(1'b0, WAKE_NIBBLE, 1'b1, pulse_gap_us);
                add_xfer(1'b0, BUS4_NIBBLE, 1'b1, pulse_gap_us);
                add_byte(1'b0, FUNC_SET_CODE, cmd_settle_us);
                add_byte(1'b0, DISPLAY_ON_CODE, cmd_settle_us);
                add_byte(1'b0, ENTRY_MODE_CODE, cmd_settle_us);
                add_byte(1'b0, CLEAR_CODE, cmd_settle_us + CLEAR_HOLD_US);
            end
            OP_CMD:    add_byte(1'b0, val, cmd_settle_us);
            OP_CHAR:   add_byte(1'b1, val, chr_settle_us);
            OP_CURSOR: add_byte(1'b0, SET_DDRAM | ddram, cmd_settle_us);
            OP_CLEAR:  add_byte(1'b0, CLEAR_CODE, cmd_settle_us + CLEAR_HOLD_US);
            default: ;
        endcase
        if (lcd_xfers_due.size() > held) begin
            lcd_xfers_due[lcd_xfers_due.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void check_xfer(t_bus_xfer got);
        t_bus_xfer want;
        if (lcd_xfers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected word: rs=%0d nib=%h pulse=%0d wait=%0d last=%0d",
                         got.rs, got.nib, got.pulse, got.wait_us, got.last);
            end
        end else begin
            want = lcd_xfers_due.pop_front();
            if (got.rs !== want.rs || got.nib !== want.nib || got.pulse !== want.pulse ||
                got.wait_us !== want.wait_us || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: expected rs=%0d nib=%h pulse=%0d wait=%0d last=%0d",
                             want.rs, want.nib, want.pulse, want.wait_us, want.last);
                    $display("          actual   rs=%0d nib=%h pulse=%0d wait=%0d last=%0d",
                             got.rs, got.nib, got.pulse, got.wait_us, got.last);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENABLE_HIGH: en_high_us    = i_cfg_data[7:0];
                    REG_AFTER_PULSE: pulse_gap_us  = i_cfg_data[9:0];
                    REG_CMD_SETTLE:  cmd_settle_us = i_cfg_data[12:0];
                    REG_CHAR_SETTLE: chr_settle_us = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                case (cur_row.kind)
                    ROW_PREDICT: predict_bus_xfers(i_cmd, i_value, i_column, i_line);
                    ROW_BYTE: begin
                        lcd_xfers_due.push_back('{cur_row.rs, cur_row.code[7:4], 1'b1,
                                                  cur_row.hi_wait, 1'b0});
                        lcd_xfers_due.push_back('{cur_row.rs, cur_row.code[3:0], 1'b1,
                                                  cur_row.lo_wait, 1'b1});
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                check_xfer('{o_register_select, o_nibble, o_pulse, o_wait_us, o_last});
            end
        end
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = drain_gappy ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // caller keeps calling back to back or lowers valid itself
    task automatic put_op(t_row r);
        int gap;
        gap = feed_gappy ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_row    = r;
        i_cmd      = r.cmd;
        i_value    = r.value;
        i_column   = r.column;
        i_line     = r.line;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_to_idle();
        i_in_valid = 1'b0;
        while (lcd_xfers_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] d);
        i_cfg_index = ix;
        i_cfg_data  = d;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [CFG_D_W-1:0] phase_cfg(int phase, t_reg_ix ix);
        logic [CFG_D_W-1:0] d;
        case (phase)
            0: d = '0;
            1: d = '1;
            2: begin
                case (ix)
                    REG_ENABLE_HIGH: d = 13'd1;
                    REG_AFTER_PULSE: d = 13'd100;
                    REG_CMD_SETTLE:  d = 13'd2000;
                    default:         d = 13'd50;
                endcase
            end
            default: d = CFG_D_W'($urandom);
        endcase
        return d;
    endfunction

    function automatic t_row random_row();
        t_row r;
        int unsigned pick;
        r        = '0;
        r.kind   = ROW_PREDICT;
        r.value  = 8'($urandom);
        r.column = 6'($urandom);
        r.line   = 1'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 5)       r.cmd = OP_INIT;
        else if (pick < 30) r.cmd = OP_CMD;
        else if (pick < 55) r.cmd = OP_CHAR;
        else if (pick < 75) r.cmd = OP_CURSOR;
        else if (pick < 88) r.cmd = OP_CLEAR;
        else                r.cmd = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        return r;
    endfunction

    initial begin
        int   k;
        int   phase;
        t_row r;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = '0;
        i_value       = '0;
        i_column      = '0;
        i_line        = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cur_row       = '0;
        mismatches    = 0;
        feed_gappy    = 1'b1;
        drain_gappy   = 1'b1;
        en_high_us    = 8'd1;
        pulse_gap_us  = 10'd100;
        cmd_settle_us = 13'd2000;
        chr_settle_us = 10'd50;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            put_op(DIRECTED[k]);
        end
        drain_to_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            feed_gappy  = (phase != 1) && ($urandom_range(0, 3) != 0);
            drain_gappy = (phase != 1) && ($urandom_range(0, 3) != 0);
            if (phase >= 3) begin
                cfg_write(CFG_IX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          CFG_D_W'($urandom));
            end
            cfg_write(REG_ENABLE_HIGH, phase_cfg(phase, REG_ENABLE_HIGH));
            cfg_write(REG_AFTER_PULSE, phase_cfg(phase, REG_AFTER_PULSE));
            cfg_write(REG_CMD_SETTLE, phase_cfg(phase, REG_CMD_SETTLE));
            cfg_write(REG_CHAR_SETTLE, phase_cfg(phase, REG_CHAR_SETTLE));
            r     = random_row();
            r.cmd = OP_INIT;
            put_op(r);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold the feed until the bus has gone quiet
                if (phase == 3 && k == ITEMS_PER_PHASE / 2) drain_to_idle();
                put_op(random_row());
            end
            drain_to_idle();
        end

        if (mismatches == 0 && lcd_xfers_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/clcd_pkg.sv
rtl/clcd_wait_sat.sv
rtl/char_lcd_4bit_interface_sequencer.sv
rtl/clcd_checker.sv
verif/tb_top.sv
